// ===== rtl/ftt_pkg.sv =====
`timescale 1ns / 1ps
package ftt_pkg;

    localparam int FLOW_SLOTS = 32;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [31:0] TCP_TIMEOUT_RST = 32'd3600000000;
    localparam logic [31:0] UDP_TIMEOUT_RST = 32'd60000000;
    localparam logic CFG_TCP_TIMEOUT = 1'b0;
    localparam logic CFG_UDP_TIMEOUT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flags;
        logic [15:0] payload_length;
        logic [31:0] timestamp;
    } t_in_beat;

    typedef struct packed {
        logic        is_udp;
        logic [31:0] flow_src_addr;
        logic [15:0] flow_src_port;
        logic [31:0] flow_dst_addr;
        logic [15:0] flow_dst_port;
        logic [31:0] first_seen;
        logic [31:0] last_seen;
        logic [31:0] fwd_packets;
        logic [31:0] fwd_bytes;
        logic [31:0] rev_packets;
        logic [31:0] rev_bytes;
        logic        last_record;
    } t_out_beat;

    // flow record held by one cell
    typedef struct packed {
        logic        is_udp;
        logic [31:0] sa;
        logic [15:0] sp;
        logic [31:0] da;
        logic [15:0] dp;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] fp;
        logic [31:0] fb;
        logic [31:0] rp;
        logic [31:0] rb;
    } t_flow;

    // command broadcast to every cell
    typedef struct packed {
        logic        is_udp;
        logic [31:0] sa;
        logic [15:0] sp;
        logic [31:0] da;
        logic [15:0] dp;
        logic [15:0] len;
        logic [31:0] ts;
    } t_key;

    // per-cell action from the controller
    typedef struct packed {
        logic add_fwd;
        logic add_rev;
        logic kill;
        logic open;
        logic stamp;
    } t_cell_op;

    // status a cell reports back
    typedef struct packed {
        logic valid;
        logic fwd_hit;
        logic rev_hit;
        logic expired;
    } t_cell_st;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SWEEP,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/ftt_cell.sv =====
`timescale 1ns / 1ps
module ftt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ftt_pkg::t_key     i_key,
    input  ftt_pkg::t_cell_op i_op,
    input  logic [31:0]       i_latest,
    input  logic [31:0]       i_tcp_to,
    input  logic [31:0]       i_udp_to,
    input  logic              i_vacant_in,
    output logic              o_vacant_out,
    output logic              o_first_free,
    output ftt_pkg::t_cell_st o_st,
    output ftt_pkg::t_flow    o_flow
);

    logic           r_valid;
    ftt_pkg::t_flow r_flow;
    logic [31:0]    w_idle;
    logic [31:0]    w_lim;
    logic           w_nz;

    // vacancy chain: first free cell is the one free with no free cell before it
    assign o_first_free = !r_valid && !i_vacant_in;
    assign o_vacant_out = i_vacant_in || !r_valid;

    // match and age checks
    assign w_idle = i_latest - r_flow.last;
    assign w_lim  = r_flow.is_udp ? i_udp_to : i_tcp_to;
    assign w_nz   = i_key.len != 16'd0;
    always_comb begin
        o_st.valid   = r_valid;
        o_st.fwd_hit = r_valid && r_flow.is_udp == i_key.is_udp &&
                       r_flow.sa == i_key.sa && r_flow.sp == i_key.sp &&
                       r_flow.da == i_key.da && r_flow.dp == i_key.dp;
        o_st.rev_hit = r_valid && r_flow.is_udp == i_key.is_udp &&
                       r_flow.sa == i_key.da && r_flow.sp == i_key.dp &&
                       r_flow.da == i_key.sa && r_flow.dp == i_key.sp;
        o_st.expired = r_valid && i_latest >= r_flow.last && w_idle >= w_lim;
    end

    // the stamp is visible on the record when it is emitted
    always_comb begin
        o_flow = r_flow;
        if (i_op.stamp) begin
            o_flow.last = i_key.ts;
        end
    end

    // a flow closed and reopened in the same cycle stays valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.open) begin
            r_valid <= 1'b1;
        end else if (i_op.kill) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.open) begin
            r_flow.is_udp <= i_key.is_udp;
            r_flow.sa     <= i_key.sa;
            r_flow.sp     <= i_key.sp;
            r_flow.da     <= i_key.da;
            r_flow.dp     <= i_key.dp;
            r_flow.first  <= i_key.ts;
            r_flow.last   <= i_key.ts;
            r_flow.fb     <= {16'd0, i_key.len};
            r_flow.fp     <= {31'd0, w_nz};
            r_flow.rb     <= 32'd0;
            r_flow.rp     <= 32'd0;
        end else begin
            if (i_op.stamp) begin
                r_flow.last <= i_key.ts;
            end
            if (i_op.add_fwd) begin
                r_flow.fb <= r_flow.fb + {16'd0, i_key.len};
                r_flow.fp <= r_flow.fp + {31'd0, w_nz};
            end
            if (i_op.add_rev) begin
                r_flow.rb <= r_flow.rb + {16'd0, i_key.len};
                r_flow.rp <= r_flow.rp + {31'd0, w_nz};
            end
        end
    end

endmodule

// ===== rtl/flow_table_tracker_top.sv =====
`timescale 1ns / 1ps
// channel | valid      | ready      | payload
// in      | i_in_valid | o_in_ready | i_in_data  (ftt_pkg::t_in_beat)
// out     | o_out_valid| i_out_ready| o_out_data (ftt_pkg::t_out_beat)
// cfg     | i_cfg_valid| o_cfg_ready| i_cfg_index, i_cfg_data
// a packet beat is latched, then applied to the cell row in the cycle after; no new beat
// is taken while a completed flow record waits in the output register.
// a sweep walks the cells one per cycle, but stalls on an expired cell while a record is
// held back and the output register is full, and it ends in a marking state (ST_EMIT).
// reset clears the valid bit of every cell at once; no clearing pass.
// input is held off while a record waits for the downstream side.
module flow_table_tracker_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ftt_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ftt_pkg::t_out_beat  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int N = ftt_pkg::FLOW_SLOTS;
    localparam int W = ftt_pkg::SLOT_W;

    ftt_pkg::t_state    r_state, n_state;
    ftt_pkg::t_in_beat  r_in;
    logic [31:0]        r_tcp_to, r_udp_to, r_latest;
    logic [W-1:0]       r_idx;
    ftt_pkg::t_out_beat r_out;
    logic               r_out_v;
    ftt_pkg::t_flow     r_pend;
    logic               r_pend_v;

    ftt_pkg::t_key      w_key;
    ftt_pkg::t_cell_op  w_op [N];
    ftt_pkg::t_cell_st  w_st [N];
    ftt_pkg::t_flow     w_flow [N];
    logic [N:0]         w_vac;
    logic [N-1:0]       w_free, w_fhit, w_rhit;
    logic               w_tcp, w_udp, w_syn, w_fin;
    logic               w_any_f, w_any_r;
    logic [W-1:0]       w_fidx, w_ridx, w_sel;
    logic               w_emit;
    logic               w_accept;
    logic               w_sweep_hit;
    logic               w_out_free;
    logic               w_sweep_go;
    logic               w_take;
    logic               w_load_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp_to <= ftt_pkg::TCP_TIMEOUT_RST;
            r_udp_to <= ftt_pkg::UDP_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ftt_pkg::CFG_TCP_TIMEOUT: r_tcp_to <= i_cfg_data;
                ftt_pkg::CFG_UDP_TIMEOUT: r_udp_to <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode of the latched beat
    assign w_tcp = r_in.protocol == ftt_pkg::PROTO_TCP;
    assign w_udp = r_in.protocol == ftt_pkg::PROTO_UDP;
    assign w_syn = w_tcp && r_in.tcp_flags[1] && !r_in.tcp_flags[4];
    assign w_fin = w_tcp && (r_in.tcp_flags[0] || r_in.tcp_flags[2]);
    always_comb begin
        w_key.is_udp = w_udp;
        w_key.sa     = r_in.source_address;
        w_key.sp     = r_in.source_port;
        w_key.da     = r_in.dest_address;
        w_key.dp     = r_in.dest_port;
        w_key.len    = r_in.payload_length;
        w_key.ts     = r_in.timestamp;
    end

    // cell row
    assign w_vac[0] = 1'b0;
    for (genvar g = 0; g < N; g++) begin : g_cell
        ftt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key        (w_key),
            .i_op         (w_op[g]),
            .i_latest     (r_latest),
            .i_tcp_to     (r_tcp_to),
            .i_udp_to     (r_udp_to),
            .i_vacant_in  (w_vac[g]),
            .o_vacant_out (w_vac[g+1]),
            .o_first_free (w_free[g]),
            .o_st         (w_st[g]),
            .o_flow       (w_flow[g])
        );
        assign w_fhit[g] = w_st[g].fwd_hit;
        assign w_rhit[g] = w_st[g].rev_hit;
    end

    // lowest matching cell
    always_comb begin
        w_fidx = '0;
        w_ridx = '0;
        for (int j = N - 1; j >= 0; j--) begin
            if (w_fhit[j]) w_fidx = W'(j);
            if (w_rhit[j]) w_ridx = W'(j);
        end
    end
    assign w_any_f = |w_fhit;
    assign w_any_r = |w_rhit;

    // sweep walk: a hit moves on only when the held record can go out
    assign w_sweep_hit = w_st[r_idx].expired;
    assign w_out_free  = !r_out_v || i_out_ready;
    assign w_sweep_go  = !w_sweep_hit || !r_pend_v || w_out_free;
    assign w_take      = r_state == ftt_pkg::ST_SWEEP && w_sweep_hit && w_sweep_go;
    assign w_load_out  = (r_state == ftt_pkg::ST_APPLY && w_emit) || (w_take && r_pend_v) ||
                         (r_state == ftt_pkg::ST_EMIT && r_pend_v && w_out_free);

    // per-cell operations
    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_op[j] = '0;
        end
        w_emit = 1'b0;
        w_sel  = w_fidx;
        if (r_state == ftt_pkg::ST_APPLY && (w_tcp || w_udp)) begin
            if (w_syn) begin
                if (w_any_f) begin
                    w_op[w_fidx].kill  = 1'b1;
                    w_op[w_fidx].stamp = 1'b1;
                    w_emit = 1'b1;
                end
                // the closed forward slot counts as free for the new flow
                for (int j = 0; j < N; j++) begin
                    if (w_any_f) begin
                        if (W'(j) == w_fidx) begin
                            w_op[j].open = !w_vac[j];
                        end else begin
                            w_op[j].open = w_free[j] && W'(j) < w_fidx;
                        end
                    end else begin
                        w_op[j].open = w_free[j];
                    end
                end
            end else if (w_fin) begin
                if (w_any_f || w_any_r) begin
                    w_sel = w_any_f ? w_fidx : w_ridx;
                    w_op[w_sel].kill  = 1'b1;
                    w_op[w_sel].stamp = 1'b1;
                    w_emit = 1'b1;
                end
            end else if (w_any_f) begin
                w_op[w_fidx].add_fwd = 1'b1;
                w_op[w_fidx].stamp   = 1'b1;
            end else if (w_any_r) begin
                w_op[w_ridx].add_rev = 1'b1;
                w_op[w_ridx].stamp   = 1'b1;
            end else if (w_udp) begin
                for (int j = 0; j < N; j++) begin
                    w_op[j].open = w_free[j];
                end
            end
        end else if (w_take) begin
            w_sel = r_idx;
            w_op[w_sel].kill = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ftt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_in_data.mode ? ftt_pkg::ST_SWEEP : ftt_pkg::ST_APPLY;
                end
            end
            ftt_pkg::ST_APPLY: n_state = ftt_pkg::ST_IDLE;
            ftt_pkg::ST_SWEEP: begin
                if (w_sweep_go && r_idx == W'(N - 1)) begin
                    n_state = ftt_pkg::ST_EMIT;
                end
            end
            ftt_pkg::ST_EMIT: begin
                if (!r_pend_v || w_out_free) n_state = ftt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    assign o_in_ready = r_state == ftt_pkg::ST_IDLE && !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ftt_pkg::ST_IDLE;
            r_latest <= 32'd0;
            r_idx    <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_idx <= '0;
                if (!i_in_data.mode) r_latest <= i_in_data.timestamp;
            end else if (r_state == ftt_pkg::ST_SWEEP && w_sweep_go) begin
                r_idx <= r_idx + 1'b1;
            end
            // output register
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            // one sweep record is held back so the final one can be marked
            if (w_take) begin
                r_pend_v <= 1'b1;
            end else if (r_state == ftt_pkg::ST_EMIT && w_out_free) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_take) begin
            r_pend <= w_flow[r_idx];
        end
        if (r_state == ftt_pkg::ST_APPLY && w_emit) begin
            r_out <= {w_flow[w_sel], 1'b1};
        end else if (w_take && r_pend_v) begin
            r_out <= {r_pend, 1'b0};
        end else if (r_state == ftt_pkg::ST_EMIT && r_pend_v && w_out_free) begin
            r_out <= {r_pend, 1'b1};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
